// ----- sv/spq_pkg.sv -----
package spq_pkg;
   localparam int QueueDepth = 16;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int FifoDepth = 2;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_EXTRACT = 3'd1,
      OP_PEEK    = 3'd2,
      OP_DELETE  = 3'd3,
      OP_UPDATE  = 3'd4,
      OP_DUMP    = 3'd5,
      OP_NOP6    = 3'd6,
      OP_NOP7    = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type         op;
      logic [63:0]        name_tag;
      logic [31:0]        time_tag;
      logic signed [15:0] pri;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_REINS,
      BK_DUMP
   } back_state_type;

   typedef struct packed {
      logic busy;
   } back_status_type;
endpackage

// ----- sv/sorted_priority_queue_core.sv -----
// Sorted priority queue core, up to spq_pkg::QueueDepth entries kept in
// descending priority order in a row of shift cells.
// Request channel: present req_* and raise start; the request is taken at
// the edge where start is high and busy is low. Opcodes 0..5 go into a
// two-entry command queue; opcodes 6 and 7 are taken and dropped.
// Result channel: rsp_valid marks one cycle per result; rsp_last flags the
// final result of a request. The receiver cannot stall, so results are
// never held.
// Flow: a request is written into the command queue, popped into the back
// end's command register from the idle state, executed in the exec state,
// and its result is registered on the output. Update adds a reinsert state,
// and dump a dump state that sends one entry per cycle for N stored entries.
// The back end pops a new command only from the idle state, once it is done
// with the last one; the command queue can take requests in the meantime.
// Reset clears the entry count, both queues and all strobes; slot contents
// are not cleared and are only read below the entry count.
module sorted_priority_queue_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [2:0]      req_opcode,
   input  logic [63:0]     req_name_tag,
   input  logic [31:0]     req_time_tag,
   input  logic signed [15:0] req_priority_req,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [63:0]     rsp_out_name_tag,
   output logic [31:0]     rsp_out_time_tag,
   output logic signed [15:0] rsp_out_priority,
   output logic            rsp_last
);
   import spq_pkg::*;

   logic            cmd_valid, cmd_pop;
   cmd_type         cmd;
   back_status_type bstat;

   spq_front u_front (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_name_tag, .req_time_tag, .req_priority_req,
      .cmd_valid, .cmd, .cmd_pop
   );

   spq_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_pop, .bstat,
      .rsp_valid, .rsp_status, .rsp_out_name_tag, .rsp_out_time_tag,
      .rsp_out_priority, .rsp_last
   );

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !bstat.busy) else $error("pop while back end busy");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !rsp_valid) else $error("result on dequeue");
endmodule

// ----- sv/spq_front.sv -----
module spq_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [2:0]      req_opcode,
   input  logic [63:0]     req_name_tag,
   input  logic [31:0]     req_time_tag,
   input  logic signed [15:0] req_priority_req,
   output logic            cmd_valid,
   output spq_pkg::cmd_type cmd,
   input  logic            cmd_pop
);
   import spq_pkg::*;

   cmd_type               fifo_ff [FifoDepth];
   logic [0:0]            rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  push;
   cmd_type               cmd_new;

   // hold off when the queue is full; ignored opcodes are dropped here
   assign busy = (cnt_ff == 2'(FifoDepth));
   assign cmd_new = '{op: opcode_type'(req_opcode), name_tag: req_name_tag,
                      time_tag: req_time_tag, pri: req_priority_req};
   assign push = start && !busy &&
                 (req_opcode != OP_NOP6) && (req_opcode != OP_NOP7);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = fifo_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff + 1'(cmd_pop && cmd_valid);
      wr_in  = wr_ff + 1'(push);
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) fifo_ff[wr_ff] <= cmd_new;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(FifoDepth)) else $error("fifo count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> !push) else $error("push while full");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff <= 2'd1)) else $error("count jump");
endmodule

// ----- sv/spq_back.sv -----
module spq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  spq_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output spq_pkg::back_status_type bstat,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [63:0]      rsp_out_name_tag,
   output logic [31:0]      rsp_out_time_tag,
   output logic signed [15:0] rsp_out_priority,
   output logic             rsp_last
);
   import spq_pkg::*;

   logic [63:0]        nm_ff [QueueDepth];
   logic [31:0]        tm_ff [QueueDepth];
   logic signed [15:0] pr_ff [QueueDepth];
   logic [CntW-1:0]    count_ff, count_in;
   back_state_type     state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [IdxW-1:0]    dix_ff, dix_in;

   logic               ov_ff, ov_in;
   logic [1:0]         os_ff, os_in;
   logic [63:0]        on_ff, on_in;
   logic [31:0]        ot_ff, ot_in;
   logic signed [15:0] op_ff, op_in;
   logic               ol_ff, ol_in;

   // cell-wise compare vectors
   logic [QueueDepth-1:0] occ, gt, hit, hit_first, rm_mask, ins_before;
   logic                  any_hit;
   logic                  do_ins, do_rm;
   logic [IdxW-1:0]       rm_pos;

   always_comb begin
      for (int i = 0; i < QueueDepth; i++) begin
         occ[i] = (CntW'(i) < count_ff);
         gt[i]  = occ[i] && (cur_ff.pri > pr_ff[i]);
         hit[i] = occ[i] && (nm_ff[i] == cur_ff.name_tag) &&
                  (tm_ff[i] == cur_ff.time_tag);
      end
      hit_first = hit & ~(hit - 1'b1);
      any_hit = |hit;
      rm_mask = '0;
      for (int i = 1; i < QueueDepth; i++)
         rm_mask[i] = rm_mask[i-1] | hit_first[i-1];
      // slot i stays ahead of the insertion point
      ins_before[0] = occ[0] & ~gt[0];
      for (int i = 1; i < QueueDepth; i++)
         ins_before[i] = ins_before[i-1] & occ[i] & ~gt[i];
      rm_pos = '0;
      for (int i = 0; i < QueueDepth; i++)
         if (hit_first[i]) rm_pos = IdxW'(i);
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      dix_in   = dix_ff;
      count_in = count_ff;
      cmd_pop  = 1'b0;
      do_ins   = 1'b0;
      do_rm    = 1'b0;
      ov_in = 1'b0; os_in = ST_OK; on_in = '0; ot_in = '0; op_in = '0; ol_in = 1'b1;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in = BK_IDLE;
            unique case (cur_ff.op)
               OP_INSERT: begin
                  if (count_ff == CntW'(QueueDepth)) begin
                     ov_in = 1'b1; os_in = ST_FULL;
                  end else begin
                     do_ins = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_EXTRACT, OP_PEEK: begin
                  ov_in = 1'b1;
                  if (count_ff == '0) os_in = ST_NOTFOUND;
                  else begin
                     on_in = nm_ff[0]; ot_in = tm_ff[0]; op_in = pr_ff[0];
                     if (cur_ff.op == OP_EXTRACT) begin
                        do_rm = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
               end
               OP_DELETE, OP_UPDATE: begin
                  if (!any_hit) begin
                     ov_in = 1'b1; os_in = ST_NOTFOUND;
                  end else begin
                     do_rm = 1'b1;
                     count_in = count_ff - 1'b1;
                     if (cur_ff.op == OP_UPDATE) state_in = BK_REINS;
                  end
               end
               OP_DUMP: begin
                  if (count_ff == '0) begin
                     ov_in = 1'b1; os_in = ST_NOTFOUND;
                  end else begin
                     dix_in = '0;
                     state_in = BK_DUMP;
                  end
               end
               default: ;
            endcase
         end
         BK_REINS: begin
            do_ins = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = BK_IDLE;
         end
         BK_DUMP: begin
            ov_in = 1'b1;
            on_in = nm_ff[dix_ff]; ot_in = tm_ff[dix_ff]; op_in = pr_ff[dix_ff];
            ol_in = (CntW'(dix_ff) + 1'b1 == count_ff);
            dix_in = dix_ff + 1'b1;
            if (ol_in) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      cur_ff <= cur_in;
      dix_ff <= dix_in;
      os_ff <= os_in; on_ff <= on_in; ot_ff <= ot_in; op_ff <= op_in; ol_ff <= ol_in;
      // cells: shift toward head on removal, away from head on insert
      for (int i = 0; i < QueueDepth; i++) begin
         if (do_rm && (rm_mask[i] || hit_first[i] || cur_ff.op == OP_EXTRACT)
             && i + 1 < QueueDepth) begin
            nm_ff[i] <= nm_ff[(i+1) % QueueDepth];
            tm_ff[i] <= tm_ff[(i+1) % QueueDepth];
            pr_ff[i] <= pr_ff[(i+1) % QueueDepth];
         end else if (do_ins && !ins_before[i]) begin
            if (i > 0 && !ins_before[(i+QueueDepth-1) % QueueDepth]) begin
               nm_ff[i] <= nm_ff[(i+QueueDepth-1) % QueueDepth];
               tm_ff[i] <= tm_ff[(i+QueueDepth-1) % QueueDepth];
               pr_ff[i] <= pr_ff[(i+QueueDepth-1) % QueueDepth];
            end else begin
               nm_ff[i] <= cur_ff.name_tag;
               tm_ff[i] <= cur_ff.time_tag;
               pr_ff[i] <= cur_ff.pri;
            end
         end
      end
   end

   assign bstat.busy       = (state_ff != BK_IDLE);
   assign rsp_valid        = ov_ff;
   assign rsp_status       = os_ff;
   assign rsp_out_name_tag = on_ff;
   assign rsp_out_time_tag = ot_ff;
   assign rsp_out_priority = op_ff;
   assign rsp_last         = ol_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth)) else $error("count overflow");
   a_onehot_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_first)) else $error("multiple first hits");
   a_reins: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_REINS |-> count_ff < CntW'(QueueDepth)) else $error("reinsert full");
   a_rm_pos: assert property (@(posedge clock) disable iff (reset)
      any_hit |-> hit[rm_pos]) else $error("bad hit index");
endmodule

// ----- tb/testbench.sv -----
module testbench;
   import spq_pkg::*;

   localparam int WatchdogLimit = 2000;

   typedef struct {
      status_type         status;
      logic [63:0]        name_tag;
      logic [31:0]        time_tag;
      logic signed [15:0] pri;
      logic               last;
   } queue_result_type;

   class queue_scoreboard;
      logic [63:0]        slot_name[QueueDepth];
      logic [31:0]        slot_time[QueueDepth];
      logic signed [15:0] slot_pri[QueueDepth];
      int                 count;
      queue_result_type   expected_results[$];
      int                 error_count;
      int                 checked_count;

      function void push_result(status_type st, int idx, logic fin);
         queue_result_type r;
         r.status = st;
         r.name_tag = (st == ST_OK) ? slot_name[idx] : '0;
         r.time_tag = (st == ST_OK) ? slot_time[idx] : '0;
         r.pri = (st == ST_OK) ? slot_pri[idx] : '0;
         r.last = fin;
         expected_results.push_back(r);
      endfunction

      function void remove_entry(int idx);
         for (int i = idx; i + 1 < count; i++) begin
            slot_name[i] = slot_name[i + 1];
            slot_time[i] = slot_time[i + 1];
            slot_pri[i] = slot_pri[i + 1];
         end
         count--;
      endfunction

      function bit place_entry(logic [63:0] nm, logic [31:0] tm, logic signed [15:0] p);
         int pos;
         pos = 0;
         if (count >= QueueDepth) return 0;
         while (pos < count && !(p > slot_pri[pos])) pos++;
         for (int i = count; i > pos; i--) begin
            slot_name[i] = slot_name[i - 1];
            slot_time[i] = slot_time[i - 1];
            slot_pri[i] = slot_pri[i - 1];
         end
         slot_name[pos] = nm;
         slot_time[pos] = tm;
         slot_pri[pos] = p;
         count++;
         return 1;
      endfunction

      function int find_key(logic [63:0] nm, logic [31:0] tm);
         for (int i = 0; i < count; i++)
            if (slot_name[i] == nm && slot_time[i] == tm) return i;
         return -1;
      endfunction

      function void note_request(opcode_type op, logic [63:0] nm, logic [31:0] tm,
                                 logic signed [15:0] p);
         int idx;
         case (op)
            OP_INSERT: begin
               if (!place_entry(nm, tm, p)) push_result(ST_FULL, 0, 1'b1);
            end
            OP_EXTRACT, OP_PEEK: begin
               if (count == 0) push_result(ST_NOTFOUND, 0, 1'b1);
               else begin
                  push_result(ST_OK, 0, 1'b1);
                  if (op == OP_EXTRACT) remove_entry(0);
               end
            end
            OP_DELETE, OP_UPDATE: begin
               idx = find_key(nm, tm);
               if (idx < 0) push_result(ST_NOTFOUND, 0, 1'b1);
               else begin
                  remove_entry(idx);
                  if (op == OP_UPDATE) void'(place_entry(nm, tm, p));
               end
            end
            OP_DUMP: begin
               if (count == 0) push_result(ST_NOTFOUND, 0, 1'b1);
               else for (int i = 0; i < count; i++) push_result(ST_OK, i, i + 1 == count);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [1:0] st, logic [63:0] nm, logic [31:0] tm,
                                 logic signed [15:0] p, logic fin);
         queue_result_type e;
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d", st);
            error_count++;
            return;
         end
         e = expected_results.pop_front();
         checked_count++;
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st); error_count++;
         end
         if (nm !== e.name_tag) begin
            $error("out_name_tag: expected %h, actual %h", e.name_tag, nm); error_count++;
         end
         if (tm !== e.time_tag) begin
            $error("out_time_tag: expected %h, actual %h", e.time_tag, tm); error_count++;
         end
         if (p !== e.pri) begin
            $error("out_priority: expected %0d, actual %0d", e.pri, p); error_count++;
         end
         if (fin !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, fin); error_count++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [2:0]         req_opcode = '0;
   logic [63:0]        req_name_tag = '0;
   logic [31:0]        req_time_tag = '0;
   logic signed [15:0] req_priority_req = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [63:0]        rsp_out_name_tag;
   logic [31:0]        rsp_out_time_tag;
   logic signed [15:0] rsp_out_priority;
   logic               rsp_last;

   queue_scoreboard    board = new();
   int                 idle_pct = 0;
   int                 stall_count = 0;
   int                 request_count = 0;
   logic [63:0]        key_names[8];
   logic [31:0]        key_times[8];

   sorted_priority_queue_core DUT (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         board.note_request(opcode_type'(req_opcode), req_name_tag, req_time_tag,
                            req_priority_req);
         request_count++;
      end
      if (!reset && rsp_valid)
         board.check_result(rsp_status, rsp_out_name_tag, rsp_out_time_tag,
                            rsp_out_priority, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= WatchdogLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Hold start high until the request is taken; random idle cycles first.
   task automatic send_request(opcode_type op, logic [63:0] nm, logic [31:0] tm,
                               logic signed [15:0] p);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_name_tag <= nm;
      req_time_tag <= tm;
      req_priority_req <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic send_random(int n);
      int k;
      int r;
      opcode_type op;
      logic [63:0] nm;
      logic [31:0] tm;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 30) op = OP_INSERT;
         else if (r < 42) op = OP_EXTRACT;
         else if (r < 52) op = OP_PEEK;
         else if (r < 66) op = OP_DELETE;
         else if (r < 82) op = OP_UPDATE;
         else if (r < 94) op = OP_DUMP;
         else op = opcode_type'($urandom_range(7, 6));
         k = $urandom_range(7);
         nm = key_names[k];
         tm = key_times[k];
         // Mostly small key pool so deletes and updates hit; sometimes a stray key.
         if ($urandom_range(9) == 0) begin
            nm = {$urandom, $urandom};
            tm = $urandom;
         end
         send_request(op, nm, tm, (r % 3 == 0) ? 16'($urandom) :
                      16'($signed($urandom_range(8)) - 4));
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         key_names[i] = {$urandom, $urandom};
         key_times[i] = $urandom;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_EXTRACT, '0, '0, '0);
      send_request(OP_PEEK, '0, '0, '0);
      send_request(OP_DUMP, '0, '0, '0);
      send_request(OP_DELETE, '1, '1, '0);
      send_request(OP_UPDATE, '1, '1, 16'sd5);
      send_request(OP_INSERT, '1, '1, 16'sh7fff);
      send_request(OP_INSERT, '0, '0, 16'sh8000);
      send_request(OP_INSERT, 64'h5555, 32'h5555, 16'sd0);
      send_request(OP_INSERT, 64'haaaa, 32'haaaa, 16'sd0);
      send_request(OP_DELETE, '1, '1, '0);
      send_request(OP_UPDATE, '0, '0, 16'sh7fff);
      send_request(OP_PEEK, '0, '0, '0);
      send_request(OP_NOP6, '1, '1, '1);
      send_request(OP_NOP7, '0, '0, '0);
      for (int i = 0; i < 15; i++)
         send_request(OP_INSERT, 64'(i), 32'(i), 16'(i % 3));
      send_request(OP_DUMP, '0, '0, '0);
      send_request(OP_EXTRACT, '0, '0, '0);
      drain_results();

      idle_pct = 38;
      send_random(140);
      drain_results();
      idle_pct = 48;
      send_random(140);
      drain_results();
      idle_pct = 0;
      send_random(120);
      drain_results();

      $display("Covered %0d requests and %0d results over all six operations,",
               request_count, board.checked_count);
      $display("full, empty and missing-key cases, and idle and back-to-back traffic.");
      if (board.error_count == 0 && board.expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
